// ===== design/dq4sb_pkg.sv =====
// ----------------------------------------------------------------------------
// dq4sb_pkg
// Shared types and constants for the 4-bit super-block dequantizer.
// ----------------------------------------------------------------------------
package dq4sb_pkg;

   localparam int unsigned SUBS       = 8;
   localparam int unsigned SUB_BYTES  = 16;
   localparam int unsigned BLOCK_BYTES = 128;
   localparam int unsigned BYTES_PER_ITEM = 4;
   localparam int unsigned LANES      = 8;
   localparam logic [31:0] CANON_NAN  = 32'h7FC0_0000;
   localparam logic [31:0] POS_INF    = 32'h7F80_0000;

   localparam logic OP_HEADER = 1'b0;
   localparam logic OP_DATA   = 1'b1;

   // decoded half: class flags, sign and exact value m * 2^(e-24), m < 2^11
   typedef struct packed {
      logic        nan;
      logic        inf;
      logic        sgn;
      logic [10:0] man;
      logic [4:0]  shf;
   } half_type;

   // per-lane exact term: value = mag * 2^(shf-24)
   typedef struct packed {
      logic        nan;
      logic        inf;
      logic        sgn;
      logic        zero;
      logic [20:0] mag;
      logic [4:0]  shf;
   } term_type;

   function automatic half_type half_decode(input logic [15:0] h);
      half_type r;
      r.sgn = h[15];
      r.nan = (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
      r.inf = (h[14:10] == 5'h1F) && (h[9:0] == 10'd0);
      if (h[14:10] == 5'd0) begin
         r.man = {1'b0, h[9:0]};
         r.shf = 5'd0;
      end else begin
         r.man = {1'b1, h[9:0]};
         r.shf = h[14:10] - 5'd1;
      end
      return r;
   endfunction

endpackage

// ===== design/dq4sb_lane.sv =====
// ----------------------------------------------------------------------------
// dq4sb_lane
// One weight: exact scale and min products, exact subtraction, one rounding.
// ----------------------------------------------------------------------------
module dq4sb_lane
   import dq4sb_pkg::*;
(
   input  logic        clock,
   input  logic        enable,
   input  half_type    d_h,
   input  half_type    m_h,
   input  logic [5:0]  sub_scale,
   input  logic [5:0]  sub_min,
   input  logic [3:0]  code,
   output logic [31:0] weight
);

   term_type a_ff, a_in, b_ff, b_in;
   logic [62:0] a_al, b_al, diff;
   logic        a_ge;
   logic        r_sgn;
   logic [5:0]  lz;
   logic [7:0]  expo;
   logic [62:0] norm;
   logic [23:0] mant;
   logic        g, st;
   logic [24:0] mr;
   logic [8:0]  e_fin;
   logic [31:0] res;

   always_comb begin
      a_in.nan  = d_h.nan || (d_h.inf && (sub_scale == 6'd0 || code == 4'd0));
      a_in.inf  = d_h.inf && !a_in.nan;
      a_in.sgn  = d_h.sgn;
      a_in.mag  = 21'(d_h.man) * 21'(sub_scale) * 21'(code);
      a_in.zero = (a_in.mag == 21'd0);
      a_in.shf  = d_h.shf;
      b_in.nan  = m_h.nan || (m_h.inf && sub_min == 6'd0);
      b_in.inf  = m_h.inf && !b_in.nan;
      b_in.sgn  = !m_h.sgn;
      b_in.mag  = 21'(m_h.man) * 21'(sub_min);
      b_in.zero = (b_in.mag == 21'd0);
      b_in.shf  = m_h.shf;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_ff <= a_in;
         b_ff <= b_in;
      end
   end

   always_comb begin
      a_al = 63'(a_ff.mag) << a_ff.shf;
      b_al = 63'(b_ff.mag) << b_ff.shf;
      a_ge = (a_al >= b_al);
      r_sgn = 1'b0;
      diff = '0;
      if (a_ff.sgn == b_ff.sgn) begin
         diff  = a_al + b_al;
         r_sgn = a_ff.sgn;
      end else if (a_ge) begin
         diff  = a_al - b_al;
         r_sgn = a_ff.sgn;
      end else begin
         diff  = b_al - a_al;
         r_sgn = b_ff.sgn;
      end
      if (diff == 63'd0) begin
         r_sgn = (a_ff.zero || a_ff.sgn) && (b_ff.zero || b_ff.sgn)
                 && (a_ff.sgn && b_ff.sgn);
      end
      lz = 6'd0;
      for (int i = 0; i < 63; i++) begin
         if (diff[i]) lz = 6'(i);
      end
      // value = diff * 2^-24, leading bit at lz; exponent lz-24, subnormal fp32 impossible
      expo = 8'(lz) + 8'd103;
      norm = diff << (6'd62 - lz);
      mant = norm[62:39];
      g    = norm[38];
      st   = |norm[37:0];
      mr   = {1'b0, mant} + 25'((g && (st || mant[0])) ? 1 : 0);
      e_fin = {1'b0, expo} + 9'(mr[24]);
      if (a_ff.nan || b_ff.nan || (a_ff.inf && b_ff.inf && a_ff.sgn != b_ff.sgn))
         res = CANON_NAN;
      else if (a_ff.inf)
         res = POS_INF | {a_ff.sgn, 31'd0};
      else if (b_ff.inf)
         res = POS_INF | {b_ff.sgn, 31'd0};
      else if (diff == 63'd0)
         res = {r_sgn, 31'd0};
      else if (mr[24])
         res = {r_sgn, e_fin[7:0], 23'd0};
      else
         res = {r_sgn, expo, mr[22:0]};
   end

   assign weight = res;

endmodule

// ===== design/dequant_4bit_superblock.sv =====
// ----------------------------------------------------------------------------
// dequant_4bit_superblock
// Header loads scales; each data transfer yields eight fp32 weights.
// ----------------------------------------------------------------------------
//  channel | direction | handshake
//  req_*   | in        | req_valid / req_ready
//  rsp_*   | out       | rsp_valid / rsp_ready
// For a data transfer the lanes register their exact products, then
// subtract, round and load the output register. One item is in work at
// a time. Reset clears the header state and counter. A stalled result
// holds in the output register.
module dequant_4bit_superblock
   import dq4sb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [47:0] req_packed_scales,
   input  logic [47:0] req_packed_mins,
   input  logic [15:0] req_scale_half,
   input  logic [15:0] req_min_half,
   input  logic [31:0] req_quant_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_weight_0,
   output logic [31:0] rsp_weight_1,
   output logic [31:0] rsp_weight_2,
   output logic [31:0] rsp_weight_3,
   output logic [31:0] rsp_weight_4,
   output logic [31:0] rsp_weight_5,
   output logic [31:0] rsp_weight_6,
   output logic [31:0] rsp_weight_7,
   output logic        rsp_block_end
);

   localparam int WPB_RAW = BLOCK_BYTES / BYTES_PER_ITEM;
   localparam int WPB     = (WPB_RAW == 0) ? 1 : WPB_RAW;
   localparam int PW      = (WPB > 1) ? $clog2(WPB) : 1;

   logic [5:0]  sc_ff [SUBS];
   logic [5:0]  mn_ff [SUBS];
   logic [15:0] ss_ff, sm_ff;
   logic [PW-1:0] pos_ff;
   logic        busy_ff, end_ff, rv_ff;
   logic [31:0] w [LANES];
   logic [31:0] wo_ff [LANES];
   logic        eo_ff;
   logic        acc, last;
   half_type    d_h, m_h;

   assign req_ready = !busy_ff && (!rv_ff || rsp_ready);
   assign acc  = req_valid && req_ready;
   assign last = (32'(pos_ff) + 32'd1 >= 32'(WPB));
   assign d_h  = half_decode(ss_ff);
   assign m_h  = half_decode(sm_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < SUBS; j++) begin
            sc_ff[j] <= '0;
            mn_ff[j] <= '0;
         end
         ss_ff <= '0; sm_ff <= '0; pos_ff <= '0;
         busy_ff <= 1'b0; rv_ff <= 1'b0;
      end else begin
         if (rv_ff && rsp_ready) rv_ff <= 1'b0;
         if (busy_ff) begin
            busy_ff <= 1'b0;
            rv_ff   <= 1'b1;
         end
         if (acc && req_opcode == OP_HEADER) begin
            for (int j = 0; j < SUBS; j++) begin
               sc_ff[j] <= req_packed_scales[6*j +: 6];
               mn_ff[j] <= req_packed_mins[6*j +: 6];
            end
            ss_ff <= req_scale_half; sm_ff <= req_min_half; pos_ff <= '0;
         end else if (acc) begin
            busy_ff <= 1'b1;
            pos_ff  <= last ? '0 : pos_ff + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         end_ff <= last;
      end
      if (busy_ff) begin
         for (int i = 0; i < LANES; i++) wo_ff[i] <= w[i];
         eo_ff <= end_ff;
      end
   end

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      logic [2:0] sb_sel;
      assign sb_sel = 3'((32'(pos_ff) * 32'(BYTES_PER_ITEM) + 32'(i / 2)) / SUB_BYTES);
      dq4sb_lane u_lane (
         .clock     (clock),
         .enable    (acc),
         .d_h       (d_h),
         .m_h       (m_h),
         .sub_scale (sc_ff[sb_sel]),
         .sub_min   (mn_ff[sb_sel]),
         .code      (req_quant_word[4*i +: 4]),
         .weight    (w[i])
      );
   end

   assign rsp_valid    = rv_ff;
   assign rsp_weight_0 = wo_ff[0];
   assign rsp_weight_1 = wo_ff[1];
   assign rsp_weight_2 = wo_ff[2];
   assign rsp_weight_3 = wo_ff[3];
   assign rsp_weight_4 = wo_ff[4];
   assign rsp_weight_5 = wo_ff[5];
   assign rsp_weight_6 = wo_ff[6];
   assign rsp_weight_7 = wo_ff[7];
   assign rsp_block_end = eo_ff;

endmodule

// ===== test/weight_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// weight_checker
// Watches the request and response channels of the super-block dequantizer,
// keeps its own copy of the header state and word counter, works out the
// eight fp32 weights of every data transfer with exact integer arithmetic
// and a single round-to-nearest-even, and compares them lane by lane.
// ----------------------------------------------------------------------------
module weight_checker
   import dq4sb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_opcode,
   input  logic [47:0] req_packed_scales,
   input  logic [47:0] req_packed_mins,
   input  logic [15:0] req_scale_half,
   input  logic [15:0] req_min_half,
   input  logic [31:0] req_quant_word,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_weight_0,
   input  logic [31:0] rsp_weight_1,
   input  logic [31:0] rsp_weight_2,
   input  logic [31:0] rsp_weight_3,
   input  logic [31:0] rsp_weight_4,
   input  logic [31:0] rsp_weight_5,
   input  logic [31:0] rsp_weight_6,
   input  logic [31:0] rsp_weight_7,
   input  logic        rsp_block_end,
   output int          fail_count,
   output int          pending_count
);

   typedef struct packed {
      logic [7:0][31:0] w;
      logic             last;
   } weight_row_type;

   weight_row_type expected_rows[$];

   logic [5:0]  sub_scale_q[8];
   logic [5:0]  sub_min_q[8];
   logic [15:0] super_scale_q;
   logic [15:0] super_min_q;
   logic [4:0]  word_pos_q;
   int          fails;

   assign fail_count    = fails;
   assign pending_count = expected_rows.size();

   initial fails = 0;

   // magnitude of a half in units of 2^-24
   function automatic longint half_units(input logic [15:0] h);
      if (h[14:10] == 5'd0) begin
         return longint'(h[9:0]);
      end
      return longint'({1'b1, h[9:0]}) << (h[14:10] - 5'd1);
   endfunction

   // fp32 of sgn * mag * 2^-24, mag nonzero and below 2^53
   function automatic logic [31:0] units_to_fp32(input logic sgn, input logic [63:0] mag);
      int          msb;
      int          sh;
      logic [63:0] mant;
      logic [63:0] rem;
      logic [63:0] half_ulp;
      msb = 0;
      for (int i = 0; i < 64; i++) begin
         if (mag[i]) begin
            msb = i;
         end
      end
      if (msb <= 23) begin
         mant = mag << (23 - msb);
      end else begin
         sh       = msb - 23;
         mant     = mag >> sh;
         rem      = mag & ((64'd1 << sh) - 64'd1);
         half_ulp = 64'd1 << (sh - 1);
         if (rem > half_ulp || (rem == half_ulp && mant[0])) begin
            mant = mant + 64'd1;
         end
         if (mant[24]) begin
            mant = mant >> 1;
            msb  = msb + 1;
         end
      end
      return {sgn, 8'(msb - 24 + 127), mant[22:0]};
   endfunction

   // (super scale * sub scale) * code - (super min * sub min)
   function automatic logic [31:0] lane_weight(input logic [15:0] dh, input logic [5:0] s,
                                               input logic [3:0] code, input logic [15:0] mh,
                                               input logic [5:0] m);
      logic   d_nan, d_inf, m_nan, m_inf, p_sgn, q_sgn;
      longint p, q, r;
      d_nan = (dh[14:10] == 5'h1F) && (dh[9:0] != 0);
      d_inf = (dh[14:10] == 5'h1F) && (dh[9:0] == 0);
      m_nan = (mh[14:10] == 5'h1F) && (mh[9:0] != 0);
      m_inf = (mh[14:10] == 5'h1F) && (mh[9:0] == 0);
      p_sgn = dh[15];
      q_sgn = mh[15];
      if (d_nan || m_nan || (d_inf && (s == 0 || code == 0)) || (m_inf && m == 0)) begin
         return CANON_NAN;
      end
      if (d_inf && m_inf) begin
         if (p_sgn == q_sgn) begin
            return CANON_NAN;
         end
         return POS_INF | {p_sgn, 31'd0};
      end
      if (d_inf) begin
         return POS_INF | {p_sgn, 31'd0};
      end
      if (m_inf) begin
         return POS_INF | {~q_sgn, 31'd0};
      end
      p = half_units(dh) * longint'(s) * longint'(code);
      q = half_units(mh) * longint'(m);
      if (p_sgn) begin
         p = -p;
      end
      if (q_sgn) begin
         q = -q;
      end
      r = p - q;
      if (r == 0) begin
         // both terms zero keep the sign of -0 - +0; exact cancellation gives +0
         if (p == 0 && q == 0) begin
            return {p_sgn & ~q_sgn, 31'd0};
         end
         return 32'd0;
      end
      if (r < 0) begin
         return units_to_fp32(1'b1, 64'(-r));
      end
      return units_to_fp32(1'b0, 64'(r));
   endfunction

   task automatic report(input string what, input int lane, input logic [31:0] got,
                         input logic [31:0] want);
      $display("%0t: mismatch %s lane %0d: got %08h, expected %08h", $time, what, lane,
               got, want);
      fails++;
   endtask

   always @(posedge clock) begin
      weight_row_type row;
      weight_row_type got;
      int             sb;
      if (reset) begin
         for (int j = 0; j < 8; j++) begin
            sub_scale_q[j] = '0;
            sub_min_q[j]   = '0;
         end
         super_scale_q = '0;
         super_min_q   = '0;
         word_pos_q    = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.w    = {rsp_weight_7, rsp_weight_6, rsp_weight_5, rsp_weight_4,
                        rsp_weight_3, rsp_weight_2, rsp_weight_1, rsp_weight_0};
            got.last = rsp_block_end;
            if (expected_rows.size() == 0) begin
               report("unexpected transfer", 0, got.w[0], 32'd0);
            end else begin
               row = expected_rows.pop_front();
               for (int k = 0; k < 8; k++) begin
                  if (got.w[k] !== row.w[k]) begin
                     report("weight", k, got.w[k], row.w[k]);
                  end
               end
               if (got.last !== row.last) begin
                  report("block_end", 8, 32'(got.last), 32'(row.last));
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_opcode == OP_HEADER) begin
               for (int j = 0; j < 8; j++) begin
                  sub_scale_q[j] = req_packed_scales[6*j +: 6];
                  sub_min_q[j]   = req_packed_mins[6*j +: 6];
               end
               super_scale_q = req_scale_half;
               super_min_q   = req_min_half;
               word_pos_q    = '0;
            end else begin
               sb = word_pos_q / 4;
               for (int k = 0; k < 4; k++) begin
                  row.w[2*k]   = lane_weight(super_scale_q, sub_scale_q[sb],
                                             req_quant_word[8*k +: 4], super_min_q,
                                             sub_min_q[sb]);
                  row.w[2*k+1] = lane_weight(super_scale_q, sub_scale_q[sb],
                                             req_quant_word[8*k+4 +: 4], super_min_q,
                                             sub_min_q[sb]);
               end
               row.last = (word_pos_q == 5'd31);
               word_pos_q = word_pos_q + 5'd1;
               expected_rows.push_back(row);
            end
         end
      end
   end

endmodule

// ===== test/dequant_4bit_superblock_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dequant_4bit_superblock_test
// Drives headers and quant words into the dequantizer with random gaps and
// response stalls: a directed pass over scale extremes, half special values
// and data before any header, then mostly a header followed by a run of
// random data words plus some loose traffic. Verdict comes from the checker.
// ----------------------------------------------------------------------------
module dequant_4bit_superblock_test;
   import dq4sb_pkg::*;

   localparam int ITEM_TARGET = 1550;
   localparam int IDLE_LIMIT  = 2000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_opcode;
   logic [47:0] req_packed_scales;
   logic [47:0] req_packed_mins;
   logic [15:0] req_scale_half;
   logic [15:0] req_min_half;
   logic [31:0] req_quant_word;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_weight_0, rsp_weight_1, rsp_weight_2, rsp_weight_3;
   logic [31:0] rsp_weight_4, rsp_weight_5, rsp_weight_6, rsp_weight_7;
   logic        rsp_block_end;
   int          fail_count;
   int          pending_count;
   int          items_sent;
   int          idle_cycles;
   int          rsp_stall;
   logic        rsp_took;
   logic        calm;

   dequant_4bit_superblock uut (.*);

   weight_checker u_checker (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      rsp_took <= rsp_valid && rsp_ready;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver: draw a stall after every transfer
   always @(negedge clock) begin
      if (rsp_took) begin
         rsp_stall = calm ? 0 : $urandom_range(0, 8);
      end
      if (rsp_stall > 0) begin
         rsp_ready = 1'b0;
         rsp_stall--;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   task automatic send_item(input logic op, input logic [47:0] ps, input logic [47:0] pm,
                            input logic [15:0] sh, input logic [15:0] mh,
                            input logic [31:0] qw);
      int gap;
      if ($urandom_range(0, 59) == 0) begin
         calm = ~calm;
      end
      gap = calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         = 1'b1;
      req_opcode        = op;
      req_packed_scales = ps;
      req_packed_mins   = pm;
      req_scale_half    = sh;
      req_min_half      = mh;
      req_quant_word    = qw;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   // hold off until every weight row has come back
   task automatic drain;
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [15:0] rand_half;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         return {1'($urandom), 5'($urandom_range(1, 30)), 10'($urandom)};
      end else if (pick < 65) begin
         return {1'($urandom), 5'd0, 10'($urandom)};
      end else if (pick < 70) begin
         return {1'($urandom), 15'd0};
      end else if (pick < 75) begin
         return {1'($urandom), 5'h1F, 10'd0};
      end else if (pick < 80) begin
         return {1'($urandom), 5'h1F, 10'($urandom_range(1, 1023))};
      end
      return 16'($urandom);
   endfunction

   function automatic logic [47:0] rand_pack;
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         return '0;
      end else if (pick == 1) begin
         return '1;
      end
      return {16'($urandom), 32'($urandom)};
   endfunction

   task automatic send_header;
      send_item(OP_HEADER, rand_pack(), rand_pack(), rand_half(), rand_half(), $urandom);
   endtask

   task automatic send_data;
      send_item(OP_DATA, rand_pack(), rand_pack(), 16'($urandom), 16'($urandom), $urandom);
   endtask

   initial begin
      int  words;
      bit  drained;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_opcode        = OP_HEADER;
      req_packed_scales = '0;
      req_packed_mins   = '0;
      req_scale_half    = '0;
      req_min_half      = '0;
      req_quant_word    = '0;
      rsp_ready         = 1'b0;
      rsp_stall         = 0;
      rsp_took          = 1'b0;
      calm              = 1'b0;
      items_sent        = 0;
      idle_cycles       = 0;
      drained           = 1'b0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // data before any header, then scale extremes and special halves
      send_item(OP_DATA, '1, '1, '1, '1, 32'hFFFF_FFFF);
      send_item(OP_DATA, '0, '0, '0, '0, 32'h0000_0000);
      send_item(OP_HEADER, '1, '1, 16'h7BFF, 16'h7BFF, '0);
      send_item(OP_DATA, '0, '0, '0, '0, 32'hFFFF_FFFF);
      send_item(OP_DATA, '0, '0, '0, '0, 32'h0000_0000);
      send_item(OP_DATA, '0, '0, '0, '0, 32'h1234_5678);
      send_item(OP_HEADER, '0, '0, 16'h0001, 16'h8001, '1);
      send_item(OP_DATA, '1, '1, '1, '1, 32'hF0F0_F0F0);
      send_item(OP_HEADER, 48'hFFF_FFFF_FFFF, '0, 16'h7C00, 16'h0000, '0);
      send_item(OP_DATA, '0, '0, '0, '0, 32'h0F0F_0F00);
      send_item(OP_HEADER, '1, '1, 16'h7E00, 16'h3C00, '0);
      send_item(OP_DATA, '0, '0, '0, '0, 32'h0000_0001);
      send_item(OP_HEADER, '1, '1, 16'h3C00, 16'hFC00, '0);
      send_item(OP_DATA, '0, '0, '0, '0, 32'h0000_0011);
      send_item(OP_HEADER, '1, '1, 16'h7C00, 16'h7C00, '0);
      send_item(OP_DATA, '0, '0, '0, '0, 32'hFFFF_FFF0);
      send_item(OP_HEADER, '0, '0, 16'hBC00, 16'h3C00, '0);
      send_item(OP_DATA, '0, '0, '0, '0, 32'h0000_0000);
      send_item(OP_HEADER, 48'h0410_4104_1041, 48'h0410_4104_1041, 16'h3C00, 16'h3C00, '0);
      send_item(OP_DATA, '0, '0, '0, '0, 32'h1111_1111);
      send_item(OP_HEADER, '1, '0, 16'hFBFF, 16'h03FF, '0);
      send_item(OP_DATA, '0, '0, '0, '0, 32'h89AB_CDEF);
      drain();

      while (items_sent < ITEM_TARGET) begin
         if (!drained && items_sent > ITEM_TARGET / 2) begin
            drain();
            drained = 1'b1;
         end
         if ($urandom_range(0, 9) != 0) begin
            words = ($urandom_range(0, 1) != 0) ? $urandom_range(32, 40)
                                                 : $urandom_range(1, 31);
            send_header();
            repeat (words) send_data();
         end else begin
            repeat ($urandom_range(1, 5)) begin
               if ($urandom_range(0, 1) != 0) begin
                  send_data();
               end else begin
                  send_header();
               end
            end
         end
      end

      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
